// ===== design/rrqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types, codes and defaults of the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int QW        = 15;
	localparam int IDW       = 8;
	localparam int TW        = 16;
	localparam int CFG_IW    = 2;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_WAIT   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_NORUN    = 2'd3;

	localparam logic [CFG_IW-1:0] REG_QNORM = 2'd0;
	localparam logic [CFG_IW-1:0] REG_QLONG = 2'd1;
	localparam logic [CFG_IW-1:0] REG_COST  = 2'd2;

	localparam logic [QW-1:0] QNORM_RST = 15'd10;
	localparam logic [QW-1:0] QLONG_RST = 15'd20;
	localparam logic [QW-1:0] COST_RST  = 15'd1;

	typedef struct packed {
		logic [1:0]     op;
		logic [IDW-1:0] task_id;
		logic           long_quantum;
		logic           idle_flag;
		logic           waiting_value;
	} in_t;

	typedef struct packed {
		logic [1:0]     status;
		logic           switched;
		logic [IDW-1:0] running_id;
		logic           running_valid;
	} out_t;

	typedef struct packed {
		logic [IDW-1:0] tid;
		logic [TW-1:0]  remain;
		logic           lq;
		logic           idl;
	} slot_t;

endpackage
`default_nettype wire

// ===== design/round_robin_quantum_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Order of work: a tick on an empty queue finishes straight away; a lasting slice is written
//   back; a reschedule rotates the expired head (if any) and then each waiting head to the
//   tail; an add scans for a free slot; set-waiting scans the slots for the id.
// Remove scans slots, then walks and compacts the queue.
// Throughput: one item at a time; busy falls in the strobe cycle, the receiver cannot stall.
// Reset: queue empty, no slot valid, nothing running, registers at 10 / 20 / 1.
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Time-slice scheduler: queue order and slot records live in two small
// synchronous memories, walked by a sequencer one entry per step.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
	parameter int SLOTS = rrqs_pkg::SLOTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  rrqs_pkg::in_t                item,
	output logic                         busy,
	output logic                         done,
	output rrqs_pkg::out_t               res,
	input  wire                          cfg_we,
	input  wire [rrqs_pkg::CFG_IW-1:0]   cfg_index,
	input  wire [rrqs_pkg::QW-1:0]       cfg_data
);
	import rrqs_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ADD      = 4'd1;
	localparam logic [3:0] S_FIND_RD  = 4'd2;
	localparam logic [3:0] S_FIND_CMP = 4'd3;
	localparam logic [3:0] S_POS_RD   = 4'd4;
	localparam logic [3:0] S_POS_CMP  = 4'd5;
	localparam logic [3:0] S_SHIFT_RD = 4'd6;
	localparam logic [3:0] S_SHIFT_WR = 4'd7;
	localparam logic [3:0] S_REM_FIN  = 4'd8;
	localparam logic [3:0] S_TICK_RD  = 4'd9;
	localparam logic [3:0] S_TICK_EX  = 4'd10;
	localparam logic [3:0] S_PICK_RD  = 4'd11;
	localparam logic [3:0] S_PICK_CHK = 4'd12;
	localparam logic [3:0] S_PICK_ID  = 4'd13;
	localparam logic [3:0] S_FIN      = 4'd14;

	// circular index add: both operands below SLOTS
	function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (SW+1)'(SLOTS)) begin
			sum = sum - (SW+1)'(SLOTS);
		end
		return sum[SW-1:0];
	endfunction

	// configuration registers
	logic [QW-1:0] qnorm_q, qlong_q, cost_q;

	// sequencer state
	logic [3:0]     state_q;
	in_t            item_q;
	logic [1:0]     status_q;
	logic           sw_q;
	logic [CW-1:0]  cnt_q;
	logic [SW-1:0]  sel_q;

	// queue bookkeeping: head pointer and fill count over the order memory
	logic [SW-1:0]  hd_q;
	logic [CW-1:0]  count_q;

	// per-slot flags held in flops (cleared at reset)
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] wait_q;

	// running task
	logic           run_q;
	logic [SW-1:0]  run_slot_q;
	logic [IDW-1:0] run_id_q;

	// result register
	logic           done_q;
	out_t           res_q;

	// queue order memory
	logic [SW-1:0]  q_mem [SLOTS];
	logic           q_we;
	logic [SW-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;

	// slot record memory
	slot_t          s_mem [SLOTS];
	logic           s_we;
	logic [SW-1:0]  s_waddr, s_raddr;
	slot_t          s_wdata, s_rdata;

	logic [SW-1:0]  cidx;
	logic [SW-1:0]  tail;
	logic [TW:0]    tdec;
	logic [QW-1:0]  refill_rd, refill_add;
	logic           tick_exp;

	assign cidx       = cnt_q[SW-1:0];
	assign tail       = wrap_add(hd_q, count_q[SW-1:0]);
	assign tdec       = {s_rdata.remain[TW-1], s_rdata.remain} - {2'b00, cost_q};
	assign refill_rd  = s_rdata.lq ? qlong_q : qnorm_q;
	assign refill_add = item_q.long_quantum ? qlong_q : qnorm_q;
	// an idle task always yields; otherwise expire once time drops to zero or below
	assign tick_exp   = s_rdata.idl || tdec[TW] || (tdec == '0);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// memory port control
	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail;
		q_wdata = q_rdata;
		q_raddr = hd_q;
		s_we    = 1'b0;
		s_waddr = run_slot_q;
		s_wdata = s_rdata;
		s_raddr = run_slot_q;
		unique case (state_q)
			S_ADD: begin
				if (!valid_q[cidx]) begin
					s_we           = 1'b1;
					s_waddr        = cidx;
					s_wdata.tid    = item_q.task_id;
					s_wdata.remain = {1'b0, refill_add};
					s_wdata.lq     = item_q.long_quantum;
					s_wdata.idl    = item_q.idle_flag;
					q_we           = 1'b1;
					q_wdata        = cidx;
				end
			end
			S_FIND_RD: begin
				s_raddr = cidx;
			end
			S_POS_RD: begin
				q_raddr = wrap_add(hd_q, cidx);
			end
			S_SHIFT_RD: begin
				q_raddr = wrap_add(hd_q, SW'(cnt_q + CW'(1)));
			end
			S_SHIFT_WR: begin
				// pull the next entry down one place
				q_we    = 1'b1;
				q_waddr = wrap_add(hd_q, cidx);
				q_wdata = q_rdata;
			end
			S_TICK_EX: begin
				s_we = 1'b1;
				if (!s_rdata.idl) begin
					s_wdata.remain = tick_exp ? {1'b0, refill_rd} : tdec[TW-1:0];
				end
				if (tick_exp) begin
					// running task is the head: rotate it to the tail
					q_we    = 1'b1;
					q_wdata = run_slot_q;
				end
			end
			S_PICK_CHK: begin
				s_raddr = q_rdata;
				if (wait_q[q_rdata]) begin
					q_we    = 1'b1;
					q_wdata = q_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		q_rdata <= q_mem[q_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			s_mem[s_waddr] <= s_wdata;
		end
		s_rdata <= s_mem[s_raddr];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qnorm_q <= QNORM_RST;
			qlong_q <= QLONG_RST;
			cost_q  <= COST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QNORM: qnorm_q <= cfg_data;
				REG_QLONG: qlong_q <= cfg_data;
				REG_COST:  cost_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			item_q     <= '0;
			status_q   <= ST_OK;
			sw_q       <= 1'b0;
			sel_q      <= '0;
			hd_q       <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			wait_q     <= '0;
			run_q      <= 1'b0;
			run_slot_q <= '0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q   <= item;
						status_q <= ST_OK;
						sw_q     <= 1'b0;
						cnt_q    <= '0;
						case (item.op)
							OP_TICK: begin
								if (count_q == '0) begin
									state_q <= S_FIN;
								end else if (!run_q) begin
									state_q <= S_PICK_RD;
								end else begin
									state_q <= S_TICK_RD;
								end
							end
							OP_ADD: begin
								// slot 0 is never handed out
								cnt_q   <= CW'(1);
								state_q <= S_ADD;
							end
							default: begin
								state_q <= S_FIND_RD;
							end
						endcase
					end
				end
				S_ADD: begin
					if (!valid_q[cidx]) begin
						valid_q[cidx] <= 1'b1;
						wait_q[cidx]  <= 1'b0;
						count_q       <= count_q + CW'(1);
						state_q       <= S_FIN;
					end else if (cnt_q == CW'(SLOTS - 1)) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CMP;
				end
				S_FIND_CMP: begin
					// lowest valid slot holding the id wins
					if (valid_q[cidx] && (s_rdata.tid == item_q.task_id)) begin
						sel_q <= cidx;
						if (item_q.op == OP_REMOVE) begin
							cnt_q   <= '0;
							state_q <= S_POS_RD;
						end else begin
							wait_q[cidx] <= item_q.waiting_value;
							state_q      <= S_FIN;
						end
					end else if (cnt_q == CW'(SLOTS - 1)) begin
						status_q <= ST_NOTFOUND;
						state_q  <= S_FIN;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_FIND_RD;
					end
				end
				S_POS_RD: begin
					state_q <= (cnt_q >= count_q) ? S_REM_FIN : S_POS_CMP;
				end
				S_POS_CMP: begin
					if (q_rdata == sel_q) begin
						count_q <= count_q - CW'(1);
						state_q <= ((cnt_q + CW'(1)) < count_q) ? S_SHIFT_RD : S_REM_FIN;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_POS_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= ((cnt_q + CW'(1)) < count_q) ? S_SHIFT_RD : S_REM_FIN;
				end
				S_REM_FIN: begin
					valid_q[sel_q] <= 1'b0;
					wait_q[sel_q]  <= 1'b0;
					if (run_q && (run_slot_q == sel_q)) begin
						run_q <= 1'b0;
						sw_q  <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_TICK_RD: begin
					state_q <= S_TICK_EX;
				end
				S_TICK_EX: begin
					if (tick_exp) begin
						hd_q    <= wrap_add(hd_q, SW'(1));
						cnt_q   <= '0;
						state_q <= S_PICK_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_PICK_RD: begin
					// a full rotation found no runnable head
					if (cnt_q >= count_q) begin
						sw_q     <= run_q;
						run_q    <= 1'b0;
						status_q <= ST_NORUN;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_PICK_CHK;
					end
				end
				S_PICK_CHK: begin
					if (wait_q[q_rdata]) begin
						hd_q    <= wrap_add(hd_q, SW'(1));
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_PICK_RD;
					end else begin
						run_q      <= 1'b1;
						run_slot_q <= q_rdata;
						sw_q       <= !(run_q && (run_slot_q == q_rdata));
						state_q    <= S_PICK_ID;
					end
				end
				S_PICK_ID: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// running id copy, loaded when a new head is chosen
	always_ff @(posedge clk) begin
		if (state_q == S_PICK_ID) begin
			run_id_q <= s_rdata.tid;
		end
		if (state_q == S_FIN) begin
			res_q.status        <= status_q;
			res_q.switched      <= sw_q;
			res_q.running_id    <= run_q ? run_id_q : '0;
			res_q.running_valid <= run_q;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(SLOTS))
		else $error("queue count reached slot count");
	a_run_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && run_q) |-> valid_q[run_slot_q])
		else $error("running slot is not valid");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_FIN && state_q == S_IDLE))
		else $error("result strobe without finishing step");
	a_slot0_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[0])
		else $error("slot 0 was allocated");
`endif

endmodule
`default_nettype wire
